/* rtl/core/slce_pkg.sv */
// Shared widths, command codes, chip codes and sequencer states of the sound log encoder.
package slce_pkg;

    localparam int MAX_WAIT_CHUNKS_DEF = 63;
    localparam int TARGET_RATE         = 44100;

    localparam int CLOCK_W   = 48;   // 32.16 sample clock
    localparam int FRAC_W    = 16;
    localparam int SAMPLES_W = CLOCK_W - FRAC_W;
    localparam int COUNT_W   = 16;
    localparam int RATE_W    = 18;
    localparam int PROD_W    = 32;   // sample_count * TARGET_RATE
    localparam int CHUNK_W   = 16;

    localparam logic [CHUNK_W-1:0] WAIT_MAX = 16'hFFFF;

    localparam logic [7:0] CMD_WAIT   = 8'h61;
    localparam logic [7:0] CMD_NES    = 8'hB4;
    localparam logic [7:0] CMD_DMG    = 8'hB3;
    localparam logic [7:0] CMD_PSG    = 8'h50;
    localparam logic [7:0] CMD_PSG_ST = 8'h4F;
    localparam logic [7:0] CMD_FM     = 8'h51;

    localparam logic [2:0] CHIP_NES    = 3'd0;
    localparam logic [2:0] CHIP_DMG    = 3'd1;
    localparam logic [2:0] CHIP_PSG    = 3'd2;
    localparam logic [2:0] CHIP_PSG_ST = 3'd3;
    localparam logic [2:0] CHIP_FM     = 3'd4;

    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_WRITE   = 1'b1;

    localparam logic [1:0] ARGS_ONE = 2'd1;
    localparam logic [1:0] ARGS_TWO = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_WAITS,
        ST_CMD
    } state_t;

endpackage

/* rtl/core/slce_divider.sv */
// Restoring divider, one quotient bit per cycle, for the sample clock increment.
module slce_divider
    import slce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CLOCK_W-1:0]   dividend,
    input  logic [RATE_W-1:0]    divisor,
    output logic                 done,
    output logic [CLOCK_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(CLOCK_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CLOCK_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RATE_W-1:0]   rem_reg, rem_next;
    logic [RATE_W-1:0]   div_reg, div_next;
    logic [CLOCK_W-1:0]  work_reg, work_next;   // dividend bits out, quotient bits in

    logic [RATE_W:0] trial;
    logic [RATE_W:0] diff;
    logic            ge;

    always_comb
    begin
        trial     = {rem_reg, work_reg[CLOCK_W-1]};
        diff      = trial - {1'b0, div_reg};
        ge        = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        work_next = work_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            div_next  = divisor;
            work_next = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            work_next = {work_reg[CLOCK_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        work_reg <= work_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

/* rtl/core/sound_log_command_encoder.sv */
// Sound log command encoder: sample clock, wait chunking and chip command output.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   kind sample_count source_rate chip
//                                            port_or_reg data_byte replay_frame
//   output    out        out_valid/out_stall cmd_byte arg_first arg_second
//                                            arg_count last
//
// Advance with nonzero rate: accept, multiply, load, 48-step divider, add.
// Zero-rate advance or run-ahead write: accepted without leaving idle.
// Write: accept, the wait commands, a step that ends them, then any chip command.
// The restoring divider and the single output register set this sequencing.
// A stalled output holds its command and the sequencer waits on it.
// Reset clears the sample clock, emitted count, fed flag and latched FM register.
module sound_log_command_encoder
    import slce_pkg::*;
#(
    parameter int MAX_WAIT_CHUNKS = MAX_WAIT_CHUNKS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [COUNT_W-1:0] sample_count,
    input  logic [RATE_W-1:0]  source_rate,
    input  logic [2:0]         chip,
    input  logic [7:0]         port_or_reg,
    input  logic [7:0]         data_byte,
    input  logic               replay_frame,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         cmd_byte,
    output logic [7:0]         arg_first,
    output logic [7:0]         arg_second,
    output logic [1:0]         arg_count,
    output logic               last
);

    localparam int N_W = $clog2(MAX_WAIT_CHUNKS + 1);
    localparam logic [N_W-1:0] N_MAX  = N_W'(MAX_WAIT_CHUNKS);
    localparam logic [N_W-1:0] N_LAST = N_W'(MAX_WAIT_CHUNKS - 1);

    state_t state_reg, state_next;

    logic [CLOCK_W-1:0]   clock_reg, clock_next;
    logic [SAMPLES_W-1:0] emitted_reg, emitted_next;
    logic                 fed_reg, fed_next;
    logic [7:0]           fm_reg_reg, fm_reg_next;
    logic [N_W-1:0]       n_reg, n_next;

    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [2:0]           chip_reg, chip_next;
    logic [7:0]           port_reg, port_next;
    logic [7:0]           data_reg, data_next;
    logic                 has_cmd_reg, has_cmd_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic [7:0]           a1_reg, a1_next;
    logic [7:0]           a2_reg, a2_next;
    logic [1:0]           acnt_reg, acnt_next;
    logic                 last_reg, last_next;

    logic                 div_start;
    logic                 div_done;
    logic [CLOCK_W-1:0]   div_quot;

    logic [SAMPLES_W:0]   diff;
    logic [SAMPLES_W-1:0] pending;
    logic                 behind;
    logic [CHUNK_W-1:0]   chunk;
    logic                 slot_free;
    logic                 more_waits;

    slce_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({prod_reg, FRAC_W'(0)}),
        .divisor  (rate_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        diff       = {1'b0, clock_reg[CLOCK_W-1:FRAC_W]} - {1'b0, emitted_reg};
        pending    = diff[SAMPLES_W-1:0];
        behind     = !diff[SAMPLES_W] && (pending != '0);
        chunk      = (|pending[SAMPLES_W-1:CHUNK_W]) ? WAIT_MAX : pending[CHUNK_W-1:0];
        slot_free  = !out_valid_reg || !out_stall;
        more_waits = fed_reg && behind && (n_reg != N_MAX);

        state_next     = state_reg;
        clock_next     = clock_reg;
        emitted_next   = emitted_reg;
        fed_next       = fed_reg;
        fm_reg_next    = fm_reg_reg;
        n_next         = n_reg;
        count_next     = count_reg;
        rate_next      = rate_reg;
        prod_next      = prod_reg;
        chip_next      = chip_reg;
        port_next      = port_reg;
        data_next      = data_reg;
        has_cmd_next   = has_cmd_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd_next       = cmd_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        acnt_next      = acnt_reg;
        last_next      = last_reg;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    count_next   = sample_count;
                    rate_next    = source_rate;
                    chip_next    = chip;
                    port_next    = port_or_reg;
                    data_next    = data_byte;
                    has_cmd_next = (chip inside {CHIP_NES, CHIP_DMG, CHIP_PSG, CHIP_PSG_ST})
                                   || (chip == CHIP_FM && port_or_reg != 8'd0);
                    n_next       = '0;
                    if (kind == KIND_ADVANCE)
                    begin
                        if (source_rate != '0)
                            state_next = ST_MUL;
                    end
                    else if (!replay_frame)
                    begin
                        if (chip == CHIP_FM && port_or_reg == 8'd0)
                            fm_reg_next = data_byte;
                        state_next = ST_WAITS;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(count_reg) * PROD_W'(TARGET_RATE);
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (div_done)
                begin
                    clock_next = clock_reg + div_quot;
                    fed_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WAITS:
            begin
                if (!more_waits)
                    state_next = has_cmd_reg ? ST_CMD : ST_IDLE;
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    cmd_next       = CMD_WAIT;
                    a1_next        = chunk[7:0];
                    a2_next        = chunk[15:8];
                    acnt_next      = ARGS_TWO;
                    last_next      = !has_cmd_reg
                                     && (!(|pending[SAMPLES_W-1:CHUNK_W]) || n_reg == N_LAST);
                    emitted_next   = emitted_reg + SAMPLES_W'(chunk);
                    n_next         = n_reg + 1'b1;
                end
            end
            ST_CMD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                    case (chip_reg)
                        CHIP_NES:
                        begin
                            cmd_next  = CMD_NES;
                            a1_next   = port_reg;
                            a2_next   = data_reg;
                            acnt_next = ARGS_TWO;
                        end
                        CHIP_DMG:
                        begin
                            cmd_next  = CMD_DMG;
                            a1_next   = port_reg;
                            a2_next   = data_reg;
                            acnt_next = ARGS_TWO;
                        end
                        CHIP_PSG:
                        begin
                            cmd_next  = CMD_PSG;
                            a1_next   = data_reg;
                            a2_next   = 8'd0;
                            acnt_next = ARGS_ONE;
                        end
                        CHIP_PSG_ST:
                        begin
                            cmd_next  = CMD_PSG_ST;
                            a1_next   = data_reg;
                            a2_next   = 8'd0;
                            acnt_next = ARGS_ONE;
                        end
                        default:
                        begin
                            // only the FM chip reaches here with a command
                            cmd_next  = CMD_FM;
                            a1_next   = fm_reg_reg;
                            a2_next   = data_reg;
                            acnt_next = ARGS_TWO;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clock_reg     <= '0;
            emitted_reg   <= '0;
            fed_reg       <= 1'b0;
            fm_reg_reg    <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            emitted_reg   <= emitted_next;
            fed_reg       <= fed_next;
            fm_reg_reg    <= fm_reg_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        rate_reg    <= rate_next;
        prod_reg    <= prod_next;
        chip_reg    <= chip_next;
        port_reg    <= port_next;
        data_reg    <= data_next;
        has_cmd_reg <= has_cmd_next;
        cmd_reg     <= cmd_next;
        a1_reg      <= a1_next;
        a2_reg      <= a2_next;
        acnt_reg    <= acnt_next;
        last_reg    <= last_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd_byte   = cmd_reg;
    assign arg_first  = a1_reg;
    assign arg_second = a2_reg;
    assign arg_count  = acnt_reg;
    assign last       = last_reg;

`ifndef NO_ASSERTIONS
    a_chunk_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_MAX)
        else $error("wait chunk count above limit");

    a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_RUN)
        else $error("divider finished outside of divide state");

    a_write_starts_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_WRITE && !replay_frame)
        |=> state_reg == ST_WAITS && n_reg == '0)
        else $error("write transaction did not start wait emission");

    a_wait_is_two_args: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAITS && $rose(out_valid_reg)) |-> cmd_reg == CMD_WAIT
        && acnt_reg == ARGS_TWO)
        else $error("wait command malformed");
`endif

endmodule
